// ===== rtl/sdsr_pkg.sv =====
// shared types and constants of the sysex data-set receiver
package sdsr_pkg;

    localparam int MAX_PAYLOAD    = 65536;
    localparam int DATA_CNT_W     = $clog2(MAX_PAYLOAD + 1);
    localparam int BYTE_CNT_W     = 17;
    localparam int INDEX_W        = 16;
    localparam int ADDR_BYTES     = 4;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_CNT_W-1:0] BYTE_COUNT_MAX = {BYTE_CNT_W{1'b1}};
    localparam logic [DATA_CNT_W-1:0] PAYLOAD_LIMIT  = DATA_CNT_W'(MAX_PAYLOAD);

    localparam logic [7:0] MANUFACTURER_ID = 8'h41;
    localparam logic [7:0] CMD_DATA_SET    = 8'h12;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_DATA   = 2'd1,
        ST_BAD_HEADER = 2'd2,
        ST_CHECKSUM   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_MODEL_ID     = 2'd0,
        REG_MODEL_ID_LEN = 2'd1,
        REG_DEVICE_ID    = 2'd2
    } reg_idx_t;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [31:0] model_id;
        logic [2:0]  model_id_length;
        logic [6:0]  device_id;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         data_byte;
        logic [31:0]        start_address;
        logic [INDEX_W-1:0] byte_index;
        status_t            status;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== rtl/sysex_data_set_receiver.sv =====
// top level of the sysex data-set receiver
// Takes one body byte of a data-set message per cycle on the input channel
// (checksum byte flagged by is_last) and returns data and status results
// through a four-entry result queue; every byte is processed in the cycle
// it is accepted, so the block sustains one byte per clock. in_ready drops
// only while fewer than two queue entries are free, since the closing byte
// can produce a data result and a status result together. Data results
// appear one byte late; the status result ends each message. Registers:
// model_id at 0x0, model_id_length at 0x4, device_id at 0x8.
module sysex_data_set_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  body_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  data_byte,
    output logic [31:0] start_address,
    output logic [15:0] byte_index,
    output logic [1:0]  status,
    output logic        last_of_run
);
    import sdsr_pkg::*;

    cfg_t    cfg;
    push_t   push;
    result_t head;
    logic    accept;

    assign accept = in_valid && in_ready;

    sdsr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdsr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .body_byte (body_byte),
        .is_last   (is_last),
        .cfg       (cfg),
        .push      (push)
    );

    sdsr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind          = head.kind;
    assign data_byte     = head.data_byte;
    assign start_address = head.start_address;
    assign byte_index    = head.byte_index;
    assign status        = head.status;
    assign last_of_run   = head.last_of_run;

endmodule

// ===== rtl/sdsr_regs.sv =====
// configuration registers with apb-style access
module sdsr_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output sdsr_pkg::cfg_t     cfg
);
    import sdsr_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MODEL_ID:     cfg_next.model_id        = pwdata;
                REG_MODEL_ID_LEN: cfg_next.model_id_length = pwdata[2:0];
                REG_DEVICE_ID:    cfg_next.device_id       = pwdata[6:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MODEL_ID:     prdata = cfg_reg.model_id;
            REG_MODEL_ID_LEN: prdata = {29'd0, cfg_reg.model_id_length};
            REG_DEVICE_ID:    prdata = {25'd0, cfg_reg.device_id};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.model_id        <= 32'd0;
            cfg_reg.model_id_length <= 3'd1;
            cfg_reg.device_id       <= 7'd16;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/sdsr_parser.sv =====
// per-byte message state and result generation
module sdsr_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     body_byte,
    input  logic           is_last,
    input  sdsr_pkg::cfg_t cfg,
    output sdsr_pkg::push_t push
);
    import sdsr_pkg::*;

    logic [BYTE_CNT_W-1:0] byte_count_reg, byte_count_next;
    logic                  mismatch_reg, mismatch_next;
    logic [6:0]            sum_reg, sum_next;
    logic [31:0]           address_reg, address_next;
    logic [7:0]            held_byte_reg, held_byte_next;
    logic                  held_valid_reg, held_valid_next;
    logic [DATA_CNT_W-1:0] data_count_reg, data_count_next;
    logic                  overflow_reg, overflow_next;

    logic [2:0]            len;
    logic [2:0]            hdr;
    logic [2:0]            pos3;
    logic [2:0]            sel;
    logic                  in_header;
    logic                  in_address;
    logic [7:0]            expect_hdr;
    logic [7:0]            model_byte;
    logic [6:0]            expect_sum;
    logic                  emit_held;
    result_t               held_res;
    result_t               status_res;
    status_t               status;

    always_comb
    begin
        if (cfg.model_id_length == 3'd0)
            len = 3'd1;
        else if (cfg.model_id_length > 3'd4)
            len = 3'd4;
        else
            len = cfg.model_id_length;
    end

    assign hdr        = len + 3'd3;
    assign pos3       = byte_count_reg[2:0];
    assign in_header  = byte_count_reg < BYTE_CNT_W'(hdr);
    assign in_address = byte_count_reg < (BYTE_CNT_W'(hdr) + BYTE_CNT_W'(ADDR_BYTES));
    assign sel        = len + 3'd1 - pos3;

    always_comb
    begin
        case (sel[1:0])
            2'd0:    model_byte = cfg.model_id[7:0];
            2'd1:    model_byte = cfg.model_id[15:8];
            2'd2:    model_byte = cfg.model_id[23:16];
            default: model_byte = cfg.model_id[31:24];
        endcase
    end

    always_comb
    begin
        if (pos3 == 3'd0)
            expect_hdr = MANUFACTURER_ID;
        else if (pos3 == 3'd1)
            expect_hdr = {1'b0, cfg.device_id};
        else if (pos3 < len + 3'd2)
            expect_hdr = model_byte;
        else
            expect_hdr = CMD_DATA_SET;
    end

    assign expect_sum = 7'd0 - sum_reg;
    assign emit_held  = held_valid_reg && !mismatch_reg;

    always_comb
    begin
        if (in_header)
            status = ST_BAD_DATA;
        else if (mismatch_reg)
            status = ST_BAD_HEADER;
        else if (body_byte != {1'b0, expect_sum})
            status = ST_CHECKSUM;
        else if (in_address)
            status = ST_BAD_DATA;
        else if (overflow_reg)
            status = ST_BAD_DATA;
        else
            status = ST_OK;
    end

    always_comb
    begin
        held_res.kind          = KIND_DATA;
        held_res.data_byte     = held_byte_reg;
        held_res.start_address = address_reg;
        held_res.byte_index    = INDEX_W'(data_count_reg - DATA_CNT_W'(1));
        held_res.status        = ST_OK;
        held_res.last_of_run   = !is_last;

        status_res.kind          = KIND_STATUS;
        status_res.data_byte     = 8'd0;
        status_res.start_address = address_reg;
        status_res.byte_index    = '0;
        status_res.status        = status;
        status_res.last_of_run   = 1'b1;
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        mismatch_next   = mismatch_reg;
        sum_next        = sum_reg;
        address_next    = address_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        data_count_next = data_count_reg;
        overflow_next   = overflow_reg;
        push.num        = 2'd0;
        push.first      = held_res;
        push.second     = status_res;

        if (accept)
        begin
            if (is_last)
            begin
                if (emit_held)
                begin
                    push.num = 2'd2;
                end
                else
                begin
                    push.num   = 2'd1;
                    push.first = status_res;
                end
                byte_count_next = '0;
                mismatch_next   = 1'b0;
                sum_next        = '0;
                address_next    = '0;
                held_byte_next  = '0;
                held_valid_next = 1'b0;
                data_count_next = '0;
                overflow_next   = 1'b0;
            end
            else
            begin
                if (in_header)
                begin
                    if (body_byte != expect_hdr)
                        mismatch_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_reg + body_byte[6:0];
                    if (in_address)
                    begin
                        address_next = {address_reg[23:0], body_byte};
                    end
                    else if (data_count_reg >= PAYLOAD_LIMIT)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        if (emit_held)
                            push.num = 2'd1;
                        held_byte_next  = body_byte;
                        held_valid_next = 1'b1;
                        data_count_next = data_count_reg + DATA_CNT_W'(1);
                    end
                end
                if (byte_count_reg != BYTE_COUNT_MAX)
                    byte_count_next = byte_count_reg + BYTE_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            mismatch_reg   <= 1'b0;
            sum_reg        <= '0;
            address_reg    <= '0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            data_count_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            mismatch_reg   <= mismatch_next;
            sum_reg        <= sum_next;
            address_reg    <= address_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            data_count_reg <= data_count_next;
            overflow_reg   <= overflow_next;
        end
    end

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.num == 2'd2 |-> push.first.kind == KIND_DATA && push.second.kind == KIND_STATUS)
        else $error("two-result push not data then status");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_last |=> byte_count_reg == '0 && !held_valid_reg && sum_reg == '0)
        else $error("message state not cleared after closing byte");

    a_no_data_on_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        push.num != 2'd0 && push.first.kind == KIND_DATA |-> !mismatch_reg)
        else $error("data emitted for a bad header");

    a_data_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        data_count_reg <= PAYLOAD_LIMIT)
        else $error("payload count past limit");

endmodule

// ===== rtl/sdsr_out_fifo.sv =====
// result queue taking up to two results per cycle
module sdsr_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  sdsr_pkg::push_t     push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output sdsr_pkg::result_t   head
);
    import sdsr_pkg::*;

    result_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg, count_next;
    logic                   pop;

    assign out_valid = count_reg != '0;
    assign room      = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign pop       = out_valid && out_ready;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.num) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.num == 2'd2)
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.num != 2'd0 |-> room)
        else $error("push without room");

    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != FIFO_CNT_W'(FIFO_DEPTH) |->
            FIFO_PTR_W'(count_reg) == FIFO_PTR_W'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule
